FILE: hdl/cgst_pkg.sv
`timescale 1ns / 1ps

package cgst_pkg;

    // table geometry
    localparam int TABLE_SIZE = 16;
    localparam int POS_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CMP_W      = 8;
    localparam int LEN_MAX    = (TABLE_SIZE > 31) ? 31 : TABLE_SIZE;

    // field widths
    localparam int SLOT_W = 16;
    localparam int ACT_W  = 3;
    localparam int IDX_W  = 5;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;

    // register port
    localparam int ADDR_W = 2;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-1:0] ADDR_MARKER = '0;
    localparam logic [SLOT_W-1:0] MARKER_RST  = 16'hFFFF;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ENTER = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LEAVE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_WRITE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TRUNC = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ  = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    // command broadcast to every cell
    typedef struct packed {
        logic              exec;
        logic [ACT_W-1:0]  action;
        logic [SLOT_W-1:0] id;
        logic [IDX_W-1:0]  idx;
        logic [SLOT_W-1:0] marker;
    } t_cell_cmd;

    // scan flag passed from cell to cell, low slot to high slot
    typedef struct packed {
        logic seen;
    } t_chain;

endpackage

FILE: hdl/cgst_req_if.sv
`timescale 1ns / 1ps

interface cgst_req_if import cgst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] group_id;
    logic [IDX_W-1:0]  slot_index;

    modport source (output valid, output action, output group_id, output slot_index,
                    input ready);
    modport sink   (input valid, input action, input group_id, input slot_index,
                    output ready);
endinterface

FILE: hdl/cgst_rsp_if.sv
`timescale 1ns / 1ps

interface cgst_rsp_if import cgst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] entry_value;
    logic [LEN_W-1:0]  used_length;

    modport source (output valid, output status, output entry_value, output used_length,
                    input ready);
    modport sink   (input valid, input status, input entry_value, input used_length,
                    output ready);
endinterface

FILE: hdl/cgst_cell.sv
`timescale 1ns / 1ps

module cgst_cell import cgst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [POS_W-1:0]  i_pos,
    input  t_cell_cmd         i_cmd,
    input  t_chain            i_chain,
    input  logic [SLOT_W-1:0] i_upper,
    output t_chain            o_chain,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_used
);

    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic              w_match;
    logic              w_empty;
    logic              w_hit;
    logic [CMP_W-1:0]  w_pos;
    logic [CMP_W-1:0]  w_idx;

    assign w_match = (r_slot == i_cmd.id);
    assign w_empty = (r_slot == i_cmd.marker);
    assign w_pos   = CMP_W'(i_pos);
    assign w_idx   = CMP_W'(i_cmd.idx);

    // enter stops at a match or an empty slot, leave at a match
    always_comb begin
        if (i_cmd.action == ACT_ENTER) begin
            w_hit = w_match | w_empty;
        end else if (i_cmd.action == ACT_LEAVE) begin
            w_hit = w_match;
        end else begin
            w_hit = 1'b0;
        end
    end

    assign o_chain.seen = i_chain.seen | w_hit;

    // next slot content
    always_comb begin
        n_slot = r_slot;
        if (i_cmd.exec) begin
            if (i_cmd.action == ACT_ENTER) begin
                if (!i_chain.seen && w_empty && !w_match) n_slot = i_cmd.id;
            end else if (i_cmd.action == ACT_LEAVE) begin
                if (i_chain.seen || w_match) n_slot = i_upper;
            end else if (i_cmd.action == ACT_WRITE) begin
                if (w_pos == w_idx) n_slot = i_cmd.id;
            end else if (i_cmd.action == ACT_TRUNC) begin
                if (w_pos >= w_idx) n_slot = i_cmd.marker;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= MARKER_RST;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;
    assign o_used = ~w_empty;

endmodule

FILE: hdl/compacting_group_set_table_unit.sv
`timescale 1ns / 1ps

// channel   | dir | handshake       | word
// i_req     | in  | valid / ready   | action, group_id, slot_index
// o_rsp     | out | valid / ready   | status, entry_value, used_length
// apb       | in  | psel / penable  | register 0 at byte 0: empty_marker
//
// each item has an execute cycle where every cell of the slot row
// updates at once, then a length cycle that loads the output register.
// the next item can be taken in the length cycle, before the last one is out.
// a full output register stalls in the length cycle until the word is taken.
// synchronous reset puts the empty marker in every slot and the register.

module compacting_group_set_table_unit import cgst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cgst_req_if.sink          i_req,
    cgst_rsp_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_LEN} t_state;

    t_state            r_state;
    logic [SLOT_W-1:0] r_marker;
    logic [ACT_W-1:0]  r_action;
    logic [SLOT_W-1:0] r_id;
    logic [IDX_W-1:0]  r_idx;
    logic [STAT_W-1:0] r_status;
    logic [SLOT_W-1:0] r_value;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [SLOT_W-1:0] r_out_value;
    logic [LEN_W-1:0]  r_out_len;

    t_cell_cmd         w_cmd;
    t_chain            w_chain [TABLE_SIZE+1];
    logic [SLOT_W-1:0] w_slot  [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] w_used;
    logic              w_out_free;
    logic              w_accept;
    logic              w_idx_ok;
    logic              w_cnt_ok;
    logic [STAT_W-1:0] w_status;
    logic [SLOT_W-1:0] w_value;
    logic [CMP_W-1:0]  w_len_raw;
    logic [LEN_W-1:0]  w_len;

    // register port
    assign pready = 1'b1;
    assign prdata = DATA_W'(r_marker);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= MARKER_RST;
        end else if (psel && penable && pwrite && paddr == ADDR_MARKER) begin
            r_marker <= pwdata[SLOT_W-1:0];
        end
    end

    // handshake
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) || (r_state == S_LEN && w_out_free);
    assign w_accept    = i_req.valid && i_req.ready;

    // command to the cell row
    assign w_cmd.exec   = (r_state == S_EXEC);
    assign w_cmd.action = r_action;
    assign w_cmd.id     = r_id;
    assign w_cmd.idx    = r_idx;
    assign w_cmd.marker = r_marker;

    assign w_chain[0].seen = 1'b0;

    // row of slot cells, data moves down one cell on leave
    for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_cell
        logic [SLOT_W-1:0] w_upper;
        if (g == TABLE_SIZE - 1) begin : g_top
            assign w_upper = r_marker;
        end else begin : g_mid
            assign w_upper = w_slot[g+1];
        end
        cgst_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pos   (POS_W'(g)),
            .i_cmd   (w_cmd),
            .i_chain (w_chain[g]),
            .i_upper (w_upper),
            .o_chain (w_chain[g+1]),
            .o_slot  (w_slot[g]),
            .o_used  (w_used[g])
        );
    end

    // status and read data of the item in execution
    assign w_idx_ok = (CMP_W'(r_idx) < CMP_W'(TABLE_SIZE));
    assign w_cnt_ok = (CMP_W'(r_idx) <= CMP_W'(TABLE_SIZE));

    always_comb begin
        w_status = ST_OK;
        w_value  = '0;
        if (r_action == ACT_ENTER) begin
            w_status = w_chain[TABLE_SIZE].seen ? ST_OK : ST_FULL;
        end else if (r_action == ACT_LEAVE) begin
            w_status = w_chain[TABLE_SIZE].seen ? ST_OK : ST_NOTFOUND;
        end else if (r_action == ACT_WRITE) begin
            w_status = w_idx_ok ? ST_OK : ST_RANGE;
        end else if (r_action == ACT_TRUNC) begin
            w_status = w_cnt_ok ? ST_OK : ST_RANGE;
        end else if (r_action == ACT_READ) begin
            if (w_idx_ok) begin
                w_value = w_slot[POS_W'(r_idx)];
            end else begin
                w_status = ST_RANGE;
            end
        end
    end

    // used length from the updated row
    always_comb begin
        w_len_raw = '0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (w_used[i]) w_len_raw = CMP_W'(i + 1);
        end
        w_len = (w_len_raw > CMP_W'(LEN_MAX)) ? LEN_W'(LEN_MAX) : w_len_raw[LEN_W-1:0];
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_LEN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_action <= i_req.action;
                r_id     <= i_req.group_id;
                r_idx    <= i_req.slot_index;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_status <= w_status;
                    r_value  <= w_value;
                    r_state  <= S_LEN;
                end
                S_LEN: begin
                    if (w_out_free) begin
                        r_out_status <= r_status;
                        r_out_value  <= r_value;
                        r_out_len    <= w_len;
                        r_state      <= w_accept ? S_EXEC : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_value = r_out_value;
    assign o_rsp.used_length = r_out_len;

    // checks
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_EXEC)
        else $error("accepted word did not start execution");

    a_exec_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |-> !i_req.ready)
        else $error("input taken during execution");

    a_exec_to_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |=> r_state == S_LEN)
        else $error("execution not followed by length cycle");

    a_leave_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.exec && r_action == ACT_LEAVE && w_chain[TABLE_SIZE].seen)
        |=> w_slot[TABLE_SIZE-1] == r_marker)
        else $error("last slot not emptied by leave");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> CMP_W'(r_out_len) <= CMP_W'(LEN_MAX))
        else $error("used length out of range");

endmodule
